[hdl/smooth_vertex_normal_accumulator_core_defines.svh]
// assertion helpers used by svna_back
`ifndef SMOOTH_VERTEX_NORMAL_ACCUMULATOR_CORE_DEFINES_SVH
`define SMOOTH_VERTEX_NORMAL_ACCUMULATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define SVNA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SVNA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SVNA_ASSERT_IMP(lbl, ante, cons)
`define SVNA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[hdl/svna_pkg.sv]
package svna_pkg;

  localparam int IDX_W  = 12;
  localparam int POS_W  = 24;
  localparam int NRM_W  = 16;
  localparam int CNT_W  = 16;
  localparam int DIF_W  = 25;
  localparam int VEC_W  = 52;
  localparam int MUL_W  = 31;
  localparam int PROD_W = 62;
  localparam int LEN_W  = 31;
  localparam int DIVN_W = 48;
  localparam int QUO_W  = 17;

  localparam logic [CNT_W-1:0] CNT_SAT = '1;
  // 1.0 in q1.15 and the largest positive q1.15 value
  localparam logic [QUO_W-1:0] Q15_ONE = 17'd32768;
  localparam logic [QUO_W-1:0] Q15_MAX = 17'd32767;

  // one triangle as it waits in the queue
  typedef struct packed {
    logic [2:0][IDX_W-1:0] idx;
    logic [8:0][POS_W-1:0] pos;
    logic [2:0]            ok;
  } tri_rec_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CROSS,
    ST_NORM_MAG,
    ST_NORM_SHIFT,
    ST_NORM_SQ,
    ST_NORM_SQRT,
    ST_NORM_DIV,
    ST_NORM_END,
    ST_CRN_READ,
    ST_CRN_PICK,
    ST_AVG_DIV,
    ST_CRN_WRITE,
    ST_CRN_OUT
  } back_state_t;

endpackage

[hdl/svna_div.sv]
module svna_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [svna_pkg::DIVN_W-1:0]   num,
  input  logic [svna_pkg::LEN_W-1:0]    den,
  output logic                          busy,
  output logic                          done,
  output logic [svna_pkg::QUO_W-1:0]    quo
);
  import svna_pkg::*;

  logic [DIVN_W-1:0] rem;
  logic [DIVN_W-1:0] dsh;
  logic [4:0]        cnt;

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= num;
        dsh  <= DIVN_W'(den) << (QUO_W - 1);
        cnt  <= 5'(QUO_W - 1);
        quo  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (rem >= dsh) begin
          rem <= rem - dsh;
          quo <= {quo[QUO_W-2:0], 1'b1};
        end else begin
          quo <= {quo[QUO_W-2:0], 1'b0};
        end
        dsh <= dsh >> 1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end

endmodule

[hdl/svna_sqrt.sv]
module svna_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [svna_pkg::PROD_W-1:0]  val,
  output logic                         done,
  output logic [svna_pkg::LEN_W-1:0]   root
);
  import svna_pkg::*;

  logic [PROD_W-1:0] rem;
  logic [PROD_W-1:0] res;
  logic [PROD_W-1:0] bitv;
  logic [4:0]        cnt;
  logic              busy;
  logic [PROD_W-1:0] trial;

  assign trial = res + bitv;
  assign root  = res[LEN_W-1:0];

  // integer square root, two radicand bits a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= val;
        res  <= '0;
        bitv <= PROD_W'(1) << (PROD_W - 2);
        cnt  <= 5'(PROD_W / 2 - 1);
        busy <= 1'b1;
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end

endmodule

[hdl/svna_front.sv]
module svna_front #(
  parameter int MAX_VERTICES = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              clear_done,
  input  logic                              tri_valid,
  output logic                              tri_stall,
  input  logic [svna_pkg::IDX_W-1:0]        corner_a_index,
  input  logic [svna_pkg::IDX_W-1:0]        corner_b_index,
  input  logic [svna_pkg::IDX_W-1:0]        corner_c_index,
  input  logic signed [svna_pkg::POS_W-1:0] pos_a_x,
  input  logic signed [svna_pkg::POS_W-1:0] pos_a_y,
  input  logic signed [svna_pkg::POS_W-1:0] pos_a_z,
  input  logic signed [svna_pkg::POS_W-1:0] pos_b_x,
  input  logic signed [svna_pkg::POS_W-1:0] pos_b_y,
  input  logic signed [svna_pkg::POS_W-1:0] pos_b_z,
  input  logic signed [svna_pkg::POS_W-1:0] pos_c_x,
  input  logic signed [svna_pkg::POS_W-1:0] pos_c_y,
  input  logic signed [svna_pkg::POS_W-1:0] pos_c_z,
  output svna_pkg::tri_rec_t                q_rec,
  output logic                              q_valid,
  input  logic                              q_pop
);
  import svna_pkg::*;

  tri_rec_t   slot [2];
  tri_rec_t   in_rec;
  logic       wp;
  logic       rp;
  logic [1:0] fill;
  logic       push;

  // classify the request: which corners address a real vertex
  always_comb begin
    in_rec.idx = {corner_c_index, corner_b_index, corner_a_index};
    in_rec.pos = {pos_c_z, pos_c_y, pos_c_x, pos_b_z, pos_b_y, pos_b_x,
                  pos_a_z, pos_a_y, pos_a_x};
    in_rec.ok  = {(32'(corner_c_index) < MAX_VERTICES),
                  (32'(corner_b_index) < MAX_VERTICES),
                  (32'(corner_a_index) < MAX_VERTICES)};
  end

  assign tri_stall = (fill == 2'd2) || !clear_done;
  assign push      = tri_valid && !tri_stall;
  assign q_valid   = (fill != 2'd0);
  assign q_rec     = slot[rp];

  // two-entry queue between intake and the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wp] <= in_rec;
  end

endmodule

[hdl/svna_back.sv]
`include "smooth_vertex_normal_accumulator_core_defines.svh"

module svna_back #(
  parameter int MAX_VERTICES = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  input  svna_pkg::tri_rec_t                 q_rec,
  input  logic                               q_valid,
  output logic                               q_pop,
  output logic                               clear_done,
  output logic                               res_valid,
  input  logic                               res_stall,
  output logic [svna_pkg::IDX_W-1:0]         vertex_index,
  output logic signed [svna_pkg::NRM_W-1:0]  normal_x,
  output logic signed [svna_pkg::NRM_W-1:0]  normal_y,
  output logic signed [svna_pkg::NRM_W-1:0]  normal_z,
  output logic [svna_pkg::CNT_W-1:0]         use_count,
  output logic                               last_corner
);
  import svna_pkg::*;

  localparam int DEPTH = (MAX_VERTICES < 4096) ? MAX_VERTICES : 4096;
  localparam int AW    = $clog2(DEPTH);

  back_state_t state, state_next;

  tri_rec_t                  rec;
  logic signed [DIF_W-1:0]   e [6];
  logic signed [VEC_W-1:0]   vec [3];
  logic [VEC_W-1:0]          mag [3];
  logic [2:0]                neg;
  logic [PROD_W-1:0]         sum;
  logic [LEN_W-1:0]          len;
  logic signed [NRM_W-1:0]   face [3];
  logic signed [NRM_W-1:0]   nrm [3];
  logic signed [NRM_W-1:0]   old [3];
  logic [CNT_W-1:0]          cnt_r;
  logic [2:0]                step;
  logic [1:0]                k;
  logic                      avg_mode;
  logic                      div_wait;
  logic [AW-1:0]             clr_addr;

  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]  prod;

  logic [CNT_W-1:0]          cnt_mem [DEPTH];
  logic [3*NRM_W-1:0]        nrm_mem [DEPTH];
  logic [CNT_W-1:0]          rd_cnt;
  logic [3*NRM_W-1:0]        rd_nrm;
  logic [AW-1:0]             rd_addr;
  logic [AW-1:0]             cnt_waddr;
  logic [CNT_W-1:0]          cnt_wdata;
  logic                      cnt_we;
  logic                      mem_we;
  logic [CNT_W-1:0]          cnt_inc;

  logic                      div_start;
  logic                      div_busy;
  logic                      div_done;
  logic [DIVN_W-1:0]         div_num;
  logic [LEN_W-1:0]          div_den;
  logic [QUO_W-1:0]          div_quo;
  logic                      sqrt_start;
  logic                      sqrt_done;
  logic [LEN_W-1:0]          sqrt_root;

  logic [VEC_W-1:0]          mxc;
  logic signed [QUO_W-1:0]   dif;
  logic [QUO_W-1:0]          dif_mag;
  logic                      res_load;

  function automatic logic [NRM_W-1:0] clamp_q15(input logic [QUO_W-1:0] q, input logic n);
    logic [QUO_W-1:0] c;
    begin
      if (n) begin
        c = (q > Q15_ONE) ? Q15_ONE : q;
        clamp_q15 = NRM_W'(-c);
      end else begin
        c = (q > Q15_MAX) ? Q15_MAX : q;
        clamp_q15 = NRM_W'(c);
      end
    end
  endfunction

  assign clear_done = (state != ST_CLEAR);
  assign rd_addr    = rec.idx[k][AW-1:0];
  assign cnt_inc    = (rd_cnt == CNT_SAT) ? rd_cnt : rd_cnt + CNT_W'(1);

  // largest component magnitude
  always_comb begin
    mxc = mag[0];
    if (mag[1] > mxc) mxc = mag[1];
    if (mag[2] > mxc) mxc = mag[2];
  end

  // running average difference for the current component
  assign dif     = QUO_W'(face[step[1:0]]) - QUO_W'(old[step[1:0]]);
  assign dif_mag = dif[QUO_W-1] ? QUO_W'(-dif) : QUO_W'(dif);

  // shared divider operands
  always_comb begin
    if (state == ST_AVG_DIV) begin
      div_num = DIVN_W'(dif_mag);
      div_den = LEN_W'(cnt_r);
    end else begin
      div_num = (DIVN_W'(mag[step[1:0]][29:0]) << 15) + DIVN_W'(len >> 1);
      div_den = len;
    end
  end

  // multiplier operand select: cross product, then squares
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == ST_CROSS) begin
      case (step)
        3'd0: begin mul_a = MUL_W'(e[1]); mul_b = MUL_W'(e[5]); end
        3'd1: begin mul_a = MUL_W'(e[2]); mul_b = MUL_W'(e[4]); end
        3'd2: begin mul_a = MUL_W'(e[2]); mul_b = MUL_W'(e[3]); end
        3'd3: begin mul_a = MUL_W'(e[0]); mul_b = MUL_W'(e[5]); end
        3'd4: begin mul_a = MUL_W'(e[0]); mul_b = MUL_W'(e[4]); end
        3'd5: begin mul_a = MUL_W'(e[1]); mul_b = MUL_W'(e[3]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state == ST_NORM_SQ && step < 3'd3) begin
      mul_a = $signed({1'b0, mag[step[1:0]][29:0]});
      mul_b = $signed({1'b0, mag[step[1:0]][29:0]});
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // next state and strobes
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    mem_we     = 1'b0;
    res_load   = 1'b0;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = ST_CROSS;
        end
      end
      ST_CROSS: begin
        if (step == 3'd6) state_next = ST_NORM_MAG;
      end
      ST_NORM_MAG: begin
        state_next = ST_NORM_SHIFT;
      end
      ST_NORM_SHIFT: begin
        if (mxc == '0) begin
          state_next = ST_NORM_END;
        end else if (mxc < (VEC_W'(1) << 30) && mxc >= (VEC_W'(1) << 29)) begin
          state_next = ST_NORM_SQ;
        end
      end
      ST_NORM_SQ: begin
        if (step == 3'd4) begin
          sqrt_start = 1'b1;
          state_next = ST_NORM_SQRT;
        end
      end
      ST_NORM_SQRT: begin
        if (sqrt_done) state_next = ST_NORM_DIV;
      end
      ST_NORM_DIV: begin
        div_start = !div_wait;
        if (div_done && step == 3'd2) state_next = ST_NORM_END;
      end
      ST_AVG_DIV: begin
        div_start = !div_wait;
        if (div_done && step == 3'd2) state_next = ST_NORM_MAG;
      end
      ST_NORM_END: begin
        state_next = avg_mode ? ST_CRN_WRITE : ST_CRN_READ;
      end
      ST_CRN_READ: begin
        state_next = rec.ok[k] ? ST_CRN_PICK : ST_CRN_OUT;
      end
      ST_CRN_PICK: begin
        state_next = (cnt_inc == CNT_W'(1)) ? ST_CRN_WRITE : ST_AVG_DIV;
      end
      ST_CRN_WRITE: begin
        mem_we     = 1'b1;
        state_next = ST_CRN_OUT;
      end
      ST_CRN_OUT: begin
        if (!res_valid || !res_stall) begin
          res_load   = 1'b1;
          state_next = (k == 2'd2) ? ST_IDLE : ST_CRN_READ;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      div_wait <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + AW'(1);
      if (div_start) div_wait <= 1'b1;
      else if (div_done) div_wait <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          rec      <= q_rec;
          e[0]     <= DIF_W'($signed(q_rec.pos[3])) - DIF_W'($signed(q_rec.pos[0]));
          e[1]     <= DIF_W'($signed(q_rec.pos[4])) - DIF_W'($signed(q_rec.pos[1]));
          e[2]     <= DIF_W'($signed(q_rec.pos[5])) - DIF_W'($signed(q_rec.pos[2]));
          e[3]     <= DIF_W'($signed(q_rec.pos[6])) - DIF_W'($signed(q_rec.pos[0]));
          e[4]     <= DIF_W'($signed(q_rec.pos[7])) - DIF_W'($signed(q_rec.pos[1]));
          e[5]     <= DIF_W'($signed(q_rec.pos[8])) - DIF_W'($signed(q_rec.pos[2]));
          step     <= '0;
          k        <= '0;
          avg_mode <= 1'b0;
        end
      end
      ST_CROSS: begin
        step <= step + 3'd1;
        case (step)
          3'd1: vec[0] <= VEC_W'(prod);
          3'd2: vec[0] <= vec[0] - VEC_W'(prod);
          3'd3: vec[1] <= VEC_W'(prod);
          3'd4: vec[1] <= vec[1] - VEC_W'(prod);
          3'd5: vec[2] <= VEC_W'(prod);
          3'd6: vec[2] <= vec[2] - VEC_W'(prod);
          default: ;
        endcase
      end
      ST_NORM_MAG: begin
        for (int i = 0; i < 3; i++) begin
          neg[i] <= vec[i][VEC_W-1];
          mag[i] <= vec[i][VEC_W-1] ? VEC_W'(-vec[i]) : VEC_W'(vec[i]);
        end
      end
      ST_NORM_SHIFT: begin
        step <= '0;
        if (mxc == '0) begin
          for (int i = 0; i < 3; i++) nrm[i] <= '0;
        end else if (mxc >= (VEC_W'(1) << 30)) begin
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
        end else if (mxc < (VEC_W'(1) << 29)) begin
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
        end
      end
      ST_NORM_SQ: begin
        step <= step + 3'd1;
        if (step == 3'd1) sum <= PROD_W'(prod);
        else if (step == 3'd2 || step == 3'd3) sum <= sum + PROD_W'(prod);
      end
      ST_NORM_SQRT: begin
        if (sqrt_done) len <= sqrt_root;
        step <= '0;
      end
      ST_NORM_DIV: begin
        if (div_done) begin
          nrm[step[1:0]] <= clamp_q15(div_quo, neg[step[1:0]]);
          step           <= step + 3'd1;
        end
      end
      ST_AVG_DIV: begin
        if (div_done) begin
          vec[step[1:0]] <= VEC_W'(old[step[1:0]]) +
                            (dif[QUO_W-1] ? -VEC_W'(div_quo) : VEC_W'(div_quo));
          step           <= step + 3'd1;
        end
      end
      ST_NORM_END: begin
        if (!avg_mode) begin
          for (int i = 0; i < 3; i++) face[i] <= nrm[i];
        end
      end
      ST_CRN_PICK: begin
        cnt_r    <= cnt_inc;
        old[0]   <= rd_nrm[3*NRM_W-1:2*NRM_W];
        old[1]   <= rd_nrm[2*NRM_W-1:NRM_W];
        old[2]   <= rd_nrm[NRM_W-1:0];
        avg_mode <= 1'b1;
        step     <= '0;
        if (cnt_inc == CNT_W'(1)) begin
          for (int i = 0; i < 3; i++) nrm[i] <= face[i];
        end
      end
      ST_CRN_OUT: begin
        if (res_load) k <= k + 2'd1;
      end
      default: ;
    endcase
  end

  // vertex tables; count table cleared by the sweep after reset
  assign cnt_we    = (state == ST_CLEAR) || mem_we;
  assign cnt_waddr = (state == ST_CLEAR) ? clr_addr : rd_addr;
  assign cnt_wdata = (state == ST_CLEAR) ? '0 : cnt_r;

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    rd_cnt <= cnt_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (mem_we) nrm_mem[rd_addr] <= {nrm[0], nrm[1], nrm[2]};
    rd_nrm <= nrm_mem[rd_addr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      vertex_index <= rec.idx[k];
      last_corner  <= (k == 2'd2);
      if (rec.ok[k]) begin
        normal_x  <= nrm[0];
        normal_y  <= nrm[1];
        normal_z  <= nrm[2];
        use_count <= cnt_r;
      end else begin
        normal_x  <= '0;
        normal_y  <= '0;
        normal_z  <= '0;
        use_count <= '0;
      end
    end
  end

  svna_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  svna_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .val   (sum),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  `SVNA_ASSERT_IMP(a_no_pop_in_clear, state == ST_CLEAR, !q_pop)
  `SVNA_ASSERT_IMP(a_div_start_free, div_start, !div_busy)
  `SVNA_ASSERT_NEXT(a_write_then_out, state == ST_CRN_WRITE, state == ST_CRN_OUT)

endmodule

[hdl/smooth_vertex_normal_accumulator_core.sv]
// Smooth vertex normal accumulator. Takes one triangle (three vertex indices and three
// Q12.12 positions) per request and returns three results, one per corner A, B, C,
// the third flagged by last_corner. After reset a sweep over min(MAX_VERTICES, 4096)
// addresses clears the use counts; no triangle is taken until it finishes. A triangle
// costs a cross product plus one normalization (a shift search, a square root and
// three 17-bit divisions); a corner needs no division on first use of its vertex, and
// on later uses three averaging divisions and a normalization. The bit-per-cycle square
// root and the shared divider set the cost of each step. Up to two triangles wait in
// the input queue.
module smooth_vertex_normal_accumulator_core #(
  parameter int MAX_VERTICES = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              tri_valid,
  output logic                              tri_stall,
  input  logic [svna_pkg::IDX_W-1:0]        corner_a_index,
  input  logic [svna_pkg::IDX_W-1:0]        corner_b_index,
  input  logic [svna_pkg::IDX_W-1:0]        corner_c_index,
  input  logic signed [svna_pkg::POS_W-1:0] pos_a_x,
  input  logic signed [svna_pkg::POS_W-1:0] pos_a_y,
  input  logic signed [svna_pkg::POS_W-1:0] pos_a_z,
  input  logic signed [svna_pkg::POS_W-1:0] pos_b_x,
  input  logic signed [svna_pkg::POS_W-1:0] pos_b_y,
  input  logic signed [svna_pkg::POS_W-1:0] pos_b_z,
  input  logic signed [svna_pkg::POS_W-1:0] pos_c_x,
  input  logic signed [svna_pkg::POS_W-1:0] pos_c_y,
  input  logic signed [svna_pkg::POS_W-1:0] pos_c_z,
  output logic                              res_valid,
  input  logic                              res_stall,
  output logic [svna_pkg::IDX_W-1:0]        vertex_index,
  output logic signed [svna_pkg::NRM_W-1:0] normal_x,
  output logic signed [svna_pkg::NRM_W-1:0] normal_y,
  output logic signed [svna_pkg::NRM_W-1:0] normal_z,
  output logic [svna_pkg::CNT_W-1:0]        use_count,
  output logic                              last_corner
);
  import svna_pkg::*;

  tri_rec_t q_rec;
  logic     q_valid;
  logic     q_pop;
  logic     clear_done;

  svna_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
    .clk            (clk),
    .rst            (rst),
    .clear_done     (clear_done),
    .tri_valid      (tri_valid),
    .tri_stall      (tri_stall),
    .corner_a_index (corner_a_index),
    .corner_b_index (corner_b_index),
    .corner_c_index (corner_c_index),
    .pos_a_x        (pos_a_x),
    .pos_a_y        (pos_a_y),
    .pos_a_z        (pos_a_z),
    .pos_b_x        (pos_b_x),
    .pos_b_y        (pos_b_y),
    .pos_b_z        (pos_b_z),
    .pos_c_x        (pos_c_x),
    .pos_c_y        (pos_c_y),
    .pos_c_z        (pos_c_z),
    .q_rec          (q_rec),
    .q_valid        (q_valid),
    .q_pop          (q_pop)
  );

  svna_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_rec        (q_rec),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .clear_done   (clear_done),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .vertex_index (vertex_index),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .normal_z     (normal_z),
    .use_count    (use_count),
    .last_corner  (last_corner)
  );

endmodule
